// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPAG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define LPAG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- rtl/lpag_pkg.sv -----
// ----------------------------------------------------------------------------
// lpag_pkg
// Types, widths and codes of the line pixel address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lpag_pkg;

  localparam int CANVAS_PIXELS = 1024;
  localparam int MAX_SPAN      = 63;

  localparam int COORD_W  = 7;
  localparam int COLOR_W  = 4;
  localparam int ADDR_W   = 10;
  localparam int STAT_W   = 2;
  localparam int STRIDE_W = 7;
  localparam int COLOFS_W = 6;
  localparam int SPAN_W   = $clog2(MAX_SPAN + 1);
  localparam int PT_W     = COORD_W + 2;
  localparam int SUM_W    = 18;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(50);
  localparam logic [COLOFS_W-1:0] COLOFS_RST = COLOFS_W'(0);

  typedef enum logic {
    REG_ROW_STRIDE = 1'b0,
    REG_COL_OFFSET = 1'b1
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_SPAN    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SETUP = 3'b010,
    S_RUN   = 3'b100
  } state_t;

  typedef struct packed {
    logic init;
    logic adv;
  } step_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W-1:0]  minor;
    logic               xmajor;
    logic               negx;
    logic               negy;
  } line_setup_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } pix_res_t;

endpackage

`default_nettype wire

// ----- rtl/lpag_in_if.sv -----
// ----------------------------------------------------------------------------
// lpag_in_if
// Line request channel: valid/ready with start point, end point and color.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpag_in_if;
  logic                           valid;
  logic                           ready;
  logic [lpag_pkg::COORD_W-1:0]   start_x;
  logic [lpag_pkg::COORD_W-1:0]   start_y;
  logic [lpag_pkg::COORD_W-1:0]   end_x;
  logic [lpag_pkg::COORD_W-1:0]   end_y;
  logic [lpag_pkg::COLOR_W-1:0]   color;

  modport source (output valid, start_x, start_y, end_x, end_y, color, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, color, output ready);
endinterface

`default_nettype wire

// ----- rtl/lpag_out_if.sv -----
// ----------------------------------------------------------------------------
// lpag_out_if
// Pixel result channel: valid/ready with address, color, status and last.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpag_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpag_pkg::ADDR_W-1:0]   pixel_addr;
  logic [lpag_pkg::COLOR_W-1:0]  pixel_color;
  logic [lpag_pkg::STAT_W-1:0]   status;
  logic                          last;

  modport source (output valid, pixel_addr, pixel_color, status, last, input ready);
  modport sink (input valid, pixel_addr, pixel_color, status, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/lpag_dda_step.sv -----
// ----------------------------------------------------------------------------
// lpag_dda_step
// Incremental remainder stepper: one compare-subtract per pixel step.
// ----------------------------------------------------------------------------
`default_nettype none

module lpag_dda_step (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lpag_pkg::step_ctl_t               ctl,
  input  wire lpag_pkg::line_setup_t             setup,
  output logic signed [lpag_pkg::PT_W-1:0]       px,
  output logic signed [lpag_pkg::PT_W-1:0]       py,
  output logic                                   last
);

  logic [lpag_pkg::SPAN_W-1:0]        acc_r, acc_nxt;
  logic [lpag_pkg::SPAN_W-1:0]        cnt_r, cnt_nxt;
  logic [lpag_pkg::SPAN_W-1:0]        span_r, minor_r;
  logic                               xmajor_r, negx_r, negy_r;
  logic signed [lpag_pkg::PT_W-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic [lpag_pkg::SPAN_W:0]          sum;
  logic                               carry;
  logic signed [lpag_pkg::PT_W-1:0]   dx, dy;

  always_comb begin
    sum   = {1'b0, acc_r} + {1'b0, minor_r};
    carry = (sum >= {1'b0, span_r});
    acc_nxt = carry ? lpag_pkg::SPAN_W'(sum - {1'b0, span_r}) : sum[lpag_pkg::SPAN_W-1:0];
    cnt_nxt = cnt_r + lpag_pkg::SPAN_W'(1);
    dx = negx_r ? -lpag_pkg::PT_W'(1) : lpag_pkg::PT_W'(1);
    dy = negy_r ? -lpag_pkg::PT_W'(1) : lpag_pkg::PT_W'(1);
    px_nxt = (xmajor_r || carry) ? px_r + dx : px_r;
    py_nxt = (!xmajor_r || carry) ? py_r + dy : py_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.init) begin
      cnt_r <= '0;
    end else if (ctl.adv) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      acc_r    <= '0;
      span_r   <= setup.span;
      minor_r  <= setup.minor;
      xmajor_r <= setup.xmajor;
      negx_r   <= setup.negx;
      negy_r   <= setup.negy;
      px_r     <= $signed(lpag_pkg::PT_W'(setup.sx));
      py_r     <= $signed(lpag_pkg::PT_W'(setup.sy));
    end else if (ctl.adv) begin
      acc_r <= acc_nxt;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
    end
  end

  assign px   = px_r;
  assign py   = py_r;
  assign last = (cnt_r == span_r);

endmodule

`default_nettype wire

// ----- rtl/lpag_addr.sv -----
// ----------------------------------------------------------------------------
// lpag_addr
// Framebuffer address and store bounds check for one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module lpag_addr (
  input  wire logic signed [lpag_pkg::PT_W-1:0]     px,
  input  wire logic signed [lpag_pkg::PT_W-1:0]     py,
  input  wire logic [lpag_pkg::STRIDE_W-1:0]        row_stride,
  input  wire logic [lpag_pkg::COLOFS_W-1:0]        col_offset,
  output lpag_pkg::pix_res_t                        res
);

  logic signed [lpag_pkg::PT_W-1:0]   py_m1;
  logic signed [lpag_pkg::SUM_W-1:0]  row_term, col_term, sum;
  logic                               outside;

  always_comb begin
    py_m1    = py - lpag_pkg::PT_W'(1);
    row_term = lpag_pkg::SUM_W'($signed({1'b0, row_stride})) * lpag_pkg::SUM_W'(py_m1);
    col_term = lpag_pkg::SUM_W'(px) - lpag_pkg::SUM_W'($signed({1'b0, col_offset}));
    sum      = row_term + col_term;
    outside  = (sum < 0) || (sum >= lpag_pkg::SUM_W'(lpag_pkg::CANVAS_PIXELS));
    res.addr   = outside ? '0 : sum[lpag_pkg::ADDR_W-1:0];
    res.status = outside ? lpag_pkg::STAT_OUTSIDE : lpag_pkg::STAT_OK;
  end

endmodule

`default_nettype wire

// ----- rtl/line_pixel_address_generator_core.sv -----
// ----------------------------------------------------------------------------
// line_pixel_address_generator_core
// Line rasterizer emitting framebuffer addresses, one transfer per pixel.
// ----------------------------------------------------------------------------
// A request is taken while the block is idle and set up in the next; then
// the stepper produces one pixel per cycle while the result side does not
// stall, span+1 pixels in all. A span-too-large request instead gives a
// single error result once the result register is free. The pixel rate is
// set by the incremental remainder stepper, which makes one compare-subtract
// per pixel. Registers: row_stride at byte 0, col_offset at byte 4; write
// them only while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module line_pixel_address_generator_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  lpag_in_if.sink                                    in_ch,
  lpag_out_if.source                                 out_ch,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [lpag_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire logic [lpag_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [lpag_pkg::CFG_DATA_W-1:0]            prdata,
  output logic                                       pready
);

  lpag_pkg::state_t                   state_r, state_nxt;
  logic [lpag_pkg::STRIDE_W-1:0]      row_stride_r;
  logic [lpag_pkg::COLOFS_W-1:0]      col_offset_r;
  logic [lpag_pkg::COORD_W-1:0]       sx_r, sy_r, ex_r, ey_r;
  logic [lpag_pkg::COLOR_W-1:0]       color_r;

  logic                               out_valid_r;
  logic [lpag_pkg::ADDR_W-1:0]        out_addr_r;
  logic [lpag_pkg::COLOR_W-1:0]       out_color_r;
  lpag_pkg::status_t                  out_status_r;
  logic                               out_last_r;

  logic                               in_xfer, out_free, load;
  logic signed [lpag_pkg::COORD_W:0]  dxs, dys;
  logic [lpag_pkg::COORD_W-1:0]       ax, ay, span_full, minor_full;
  logic                               xmajor, too_big;
  lpag_pkg::line_setup_t              setup;
  lpag_pkg::step_ctl_t                step_ctl;
  logic signed [lpag_pkg::PT_W-1:0]   px, py;
  logic                               step_last;
  lpag_pkg::pix_res_t                 pix;
  logic                               cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_stride_r <= lpag_pkg::STRIDE_RST;
      col_offset_r <= lpag_pkg::COLOFS_RST;
    end else if (cfg_wr) begin
      unique case (lpag_pkg::reg_idx_t'(paddr[2]))
        lpag_pkg::REG_ROW_STRIDE: row_stride_r <= pwdata[lpag_pkg::STRIDE_W-1:0];
        lpag_pkg::REG_COL_OFFSET: col_offset_r <= pwdata[lpag_pkg::COLOFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (lpag_pkg::reg_idx_t'(paddr[2]))
      lpag_pkg::REG_ROW_STRIDE: prdata = lpag_pkg::CFG_DATA_W'(row_stride_r);
      lpag_pkg::REG_COL_OFFSET: prdata = lpag_pkg::CFG_DATA_W'(col_offset_r);
      default:                  prdata = '0;
    endcase
  end

  // request latch
  assign in_ch.ready = (state_r == lpag_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sx_r    <= in_ch.start_x;
      sy_r    <= in_ch.start_y;
      ex_r    <= in_ch.end_x;
      ey_r    <= in_ch.end_y;
      color_r <= in_ch.color;
    end
  end

  // line setup
  always_comb begin
    dxs        = $signed({1'b0, ex_r}) - $signed({1'b0, sx_r});
    dys        = $signed({1'b0, ey_r}) - $signed({1'b0, sy_r});
    ax         = (dxs < 0) ? lpag_pkg::COORD_W'(-dxs) : lpag_pkg::COORD_W'(dxs);
    ay         = (dys < 0) ? lpag_pkg::COORD_W'(-dys) : lpag_pkg::COORD_W'(dys);
    xmajor     = (ax >= ay);
    span_full  = xmajor ? ax : ay;
    minor_full = xmajor ? ay : ax;
    too_big    = (span_full > lpag_pkg::COORD_W'(lpag_pkg::MAX_SPAN));
    setup.sx     = sx_r;
    setup.sy     = sy_r;
    setup.span   = span_full[lpag_pkg::SPAN_W-1:0];
    setup.minor  = minor_full[lpag_pkg::SPAN_W-1:0];
    setup.xmajor = xmajor;
    setup.negx   = (ex_r < sx_r);
    setup.negy   = (ey_r < sy_r);
  end

  assign out_free = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_ctl.init = 1'b0;
    step_ctl.adv  = 1'b0;
    load          = 1'b0;
    unique case (state_r)
      lpag_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = lpag_pkg::S_SETUP;
      end
      lpag_pkg::S_SETUP: begin
        if (too_big) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = lpag_pkg::S_IDLE;
          end
        end else begin
          step_ctl.init = 1'b1;
          state_nxt     = lpag_pkg::S_RUN;
        end
      end
      lpag_pkg::S_RUN: begin
        if (out_free) begin
          load = 1'b1;
          if (step_last) state_nxt = lpag_pkg::S_IDLE;
          else           step_ctl.adv = 1'b1;
        end
      end
      default: state_nxt = lpag_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpag_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  lpag_dda_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (step_ctl),
    .setup (setup),
    .px    (px),
    .py    (py),
    .last  (step_last)
  );

  lpag_addr u_addr (
    .px         (px),
    .py         (py),
    .row_stride (row_stride_r),
    .col_offset (col_offset_r),
    .res        (pix)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_color_r <= color_r;
      if (state_r == lpag_pkg::S_SETUP) begin
        out_addr_r   <= '0;
        out_status_r <= lpag_pkg::STAT_SPAN;
        out_last_r   <= 1'b1;
      end else begin
        out_addr_r   <= pix.addr;
        out_status_r <= pix.status;
        out_last_r   <= step_last;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_addr  = out_addr_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last        = out_last_r;

  `LPAG_ASSERT_NXT(a_accept_setup, clk, rst_n, in_xfer, state_r == lpag_pkg::S_SETUP)
  `LPAG_ASSERT_IMP(a_err_zero_addr, clk, rst_n,
                   out_valid_r && (out_status_r != lpag_pkg::STAT_OK), out_addr_r == '0)
  `LPAG_ASSERT_IMP(a_span_err_last, clk, rst_n,
                   out_valid_r && (out_status_r == lpag_pkg::STAT_SPAN), out_last_r)
  `LPAG_ASSERT_NXT(a_last_to_idle, clk, rst_n,
                   load && (state_r == lpag_pkg::S_RUN) && step_last,
                   (state_r == lpag_pkg::S_IDLE) && out_valid_r && out_last_r)

endmodule

`default_nettype wire
